[rtl/core/tlgs_pkg.sv]
// Shared types and constants for the toroidal life grid block.
// Used by the controller, the datapath, the top level and the checker.
package tlgs_pkg;

    // Default grid bounds
    localparam int TLGS_MAX_WIDTH  = 64;
    localparam int TLGS_MAX_HEIGHT = 64;

    // Size register reset value
    localparam int DEF_GRID_SIZE = 64;

    // Item operation codes (carried on tuser)
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = 7;
    localparam logic [0:0]  CFG_GRID_W  = 1'b0;
    localparam logic [0:0]  CFG_GRID_H  = 1'b1;

    // Life rule neighbor counts
    localparam logic [3:0] LIFE_KEEP  = 4'd2;
    localparam logic [3:0] LIFE_BIRTH = 4'd3;

    // Request field layout, input side
    localparam int FUNC_W      = 2;
    localparam int CELL_COL_W  = 7;
    localparam int CELL_ROW_W  = 7;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int IN_COL_LSB  = 0;
    localparam int IN_ROW_LSB  = 7;
    localparam int IN_VAL_BIT  = 14;

    // Result field layout, output side
    localparam int GEN_W       = 32;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_RV_BIT  = 0;
    localparam int OUT_GEN_LSB = 1;
    localparam int OUT_OOR_BIT = 33;

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // latch request fields
        logic cell_rd;   // read column of addressed cell
        logic cell_upd;  // column data present: modify or sample
        logic step_rd;   // issue one sweep read
        logic step_fin;  // swap banks, count generation
        logic load_res;  // load output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              oor;
        logic              sweep_last;
        logic              out_busy;
    } t_status;

endpackage

[rtl/core/toroidal_life_grid_step_top.sv]
// Toroidal life grid block. A cell write or read passes through the dispatch and cell
// states before its result loads (an out-of-range request or an unused code skips the
// cell state); a generation step makes MAX_WIDTH + 2 column reads through the single
// read port, then drains the window. One request at a time: the next is taken in the
// cycle after the result loads; a stalled result holds the block. Sync active-low reset:
// all cells dead at once.
module toroidal_life_grid_step_top
    import tlgs_pkg::*;
#(
    parameter int MAX_WIDTH  = TLGS_MAX_WIDTH,
    parameter int MAX_HEIGHT = TLGS_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [6:0] cell_col, [13:7] cell_row, [14] cell_value, [15] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] func
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] read_value, [32:1] generation_count, [33] out_of_range, [39:34] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cmd    cmd;
    t_status sts;

    tlgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlgs_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_out_ready (i_m_axis_tready)
    );

endmodule

[rtl/core/tlgs_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tlgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tlgs_ctrl.sv]
// Sequencing state machine for the life grid block.
// Depends on tlgs_pkg for command and status types and operation codes.
module tlgs_ctrl
    import tlgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_CELL  = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.func) inside
                    FUNC_WRITE, FUNC_READ: begin
                        if (i_sts.oor) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.cell_rd = 1'b1;
                            n_state       = S_CELL;
                        end
                    end
                    FUNC_STEP: begin
                        n_state = S_STEP;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CELL: begin
                o_cmd.cell_upd = 1'b1;
                n_state        = S_DONE;
            end
            S_STEP: begin
                o_cmd.step_rd = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.step_fin = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/tlgs_dpath.sv]
// Datapath: size registers, two column-organized cell banks, sweep window,
// life rule, generation counter and output register.
// Depends on tlgs_pkg and tlgs_ram.
module tlgs_dpath
    import tlgs_pkg::*;
#(
    parameter int MAX_WIDTH  = TLGS_MAX_WIDTH,
    parameter int MAX_HEIGHT = TLGS_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  t_cmd                  i_cmd,
    output t_status               o_sts,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    input  logic                  i_out_ready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int GWW = $clog2(MAX_WIDTH + 1);
    localparam int GHW = $clog2(MAX_HEIGHT + 1);
    localparam int KW  = $clog2(MAX_WIDTH + 2);
    localparam int FWW = ((GWW > CELL_COL_W) ? GWW : CELL_COL_W) + 1;
    localparam int FHW = ((GHW > CELL_ROW_W) ? GHW : CELL_ROW_W) + 1;
    localparam int GW_RST = (DEF_GRID_SIZE > MAX_WIDTH) ? MAX_WIDTH : DEF_GRID_SIZE;
    localparam int GH_RST = (DEF_GRID_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : DEF_GRID_SIZE;
    localparam logic [KW-1:0] K_LAST = KW'(MAX_WIDTH + 1);

    // Size registers
    logic [GWW-1:0] r_gw;
    logic [GHW-1:0] r_gh;
    logic [GWW-1:0] n_gw;
    logic [GHW-1:0] n_gh;

    // Latched request
    logic [FUNC_W-1:0] r_func;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic              r_val;
    logic              r_oor;
    logic              r_rv;

    // Bank and sweep state
    logic                  r_bank;
    logic [GEN_W-1:0]      r_gen;
    logic [KW-1:0]         r_k;
    logic [MAX_WIDTH-1:0]  r_vld_a;
    logic [MAX_WIDTH-1:0]  r_vld_b;
    logic                  r_rd_vbit;
    logic                  r_rd_step;
    logic [KW-1:0]         r_rd_tag;
    logic [MAX_HEIGHT-1:0] r_left;
    logic [MAX_HEIGHT-1:0] r_mid;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Fold of incoming coordinates
    logic [FWW-1:0] col_ext;
    logic [FWW-1:0] gw_ext;
    logic [FWW-1:0] col_fold;
    logic [FHW-1:0] row_ext;
    logic [FHW-1:0] gh_ext;
    logic [FHW-1:0] row_fold;
    logic           fold_oor;

    // Memory side
    logic                  rd_en;
    logic [CW-1:0]         rd_addr;
    logic [KW-1:0]         gw_k;
    logic [KW-1:0]         sweep_k;
    logic [MAX_HEIGHT-1:0] q_a;
    logic [MAX_HEIGHT-1:0] q_b;
    logic [MAX_HEIGHT-1:0] q;
    logic                  step_wr;
    logic                  step_calc;
    logic                  cell_wr;
    logic [MAX_HEIGHT-1:0] cell_new;
    logic [MAX_HEIGHT-1:0] life_col;
    logic [MAX_HEIGHT-1:0] wdata;
    logic [CW-1:0]         waddr;
    logic                  we_a;
    logic                  we_b;
    logic [RW-1:0]         gh_m1;

    // Size register clamp: zero reads as one, oversize as the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            n_gw = GWW'(1);
            n_gh = GHW'(1);
        end else begin
            n_gw = (int'(i_cfg_data) > MAX_WIDTH)  ? GWW'(MAX_WIDTH)  : GWW'(i_cfg_data);
            n_gh = (int'(i_cfg_data) > MAX_HEIGHT) ? GHW'(MAX_HEIGHT) : GHW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GWW'(GW_RST);
            r_gh <= GHW'(GH_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_W: r_gw <= n_gw;
                CFG_GRID_H: r_gh <= n_gh;
                default: ;
            endcase
        end
    end

    // One fold back by the grid size, then range check
    always_comb begin
        col_ext  = FWW'(i_in_data[IN_COL_LSB +: CELL_COL_W]);
        gw_ext   = FWW'(r_gw);
        col_fold = (col_ext >= gw_ext) ? (col_ext - gw_ext) : col_ext;
        row_ext  = FHW'(i_in_data[IN_ROW_LSB +: CELL_ROW_W]);
        gh_ext   = FHW'(r_gh);
        row_fold = (row_ext >= gh_ext) ? (row_ext - gh_ext) : row_ext;
        fold_oor = (col_fold >= gw_ext) || (row_fold >= gh_ext);
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func <= i_in_user[FUNC_W-1:0];
            r_col  <= CW'(col_fold);
            r_row  <= RW'(row_fold);
            r_val  <= i_in_data[IN_VAL_BIT];
            r_oor  <= fold_oor && ((i_in_user[FUNC_W-1:0] == FUNC_WRITE) ||
                                   (i_in_user[FUNC_W-1:0] == FUNC_READ));
        end
    end

    // Sweep read order: last column, columns 0..gw-1, column 0 again,
    // then the unused columns gw..MAX_WIDTH-1 for the copy.
    always_comb begin
        gw_k = KW'(r_gw);
        if (r_k == '0) begin
            sweep_k = gw_k - 1'b1;
        end else if (r_k <= gw_k) begin
            sweep_k = r_k - 1'b1;
        end else if (r_k == gw_k + 1'b1) begin
            sweep_k = '0;
        end else begin
            sweep_k = r_k - KW'(2);
        end
    end

    assign rd_en   = i_cmd.cell_rd | i_cmd.step_rd;
    assign rd_addr = i_cmd.step_rd ? CW'(sweep_k) : r_col;

    // Sweep counter and read tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_rd_step <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_k <= '0;
            end else if (i_cmd.step_rd) begin
                r_k <= r_k + 1'b1;
            end
            r_rd_step <= i_cmd.step_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag <= r_k;
        if (rd_en) begin
            r_rd_vbit <= r_bank ? r_vld_b[rd_addr] : r_vld_a[rd_addr];
        end
    end

    // Banks; a column never written reads as all dead
    tlgs_ram #(
        .WIDTH (MAX_HEIGHT),
        .DEPTH (MAX_WIDTH)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (q_a)
    );

    tlgs_ram #(
        .WIDTH (MAX_HEIGHT),
        .DEPTH (MAX_WIDTH)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (q_b)
    );

    assign q = (r_bank ? q_b : q_a) & {MAX_HEIGHT{r_rd_vbit}};

    // Three-column window: left and middle held, right is the read data
    always_ff @(posedge i_clk) begin
        if (r_rd_step && (r_rd_tag <= gw_k + 1'b1)) begin
            r_left <= r_mid;
            r_mid  <= q;
        end
    end

    // Life rule per row, rows wrapped once by the height
    assign gh_m1 = RW'(r_gh - 1'b1);

    for (genvar r = 0; r < MAX_HEIGHT; r++) begin : g_row
        logic up_l, up_c, up_r;
        logic dn_l, dn_c, dn_r;
        logic [3:0] cnt;
        logic alive;

        if (r == 0) begin : g_up_wrap
            assign up_l = r_left[gh_m1];
            assign up_c = r_mid[gh_m1];
            assign up_r = q[gh_m1];
        end else begin : g_up
            assign up_l = r_left[r-1];
            assign up_c = r_mid[r-1];
            assign up_r = q[r-1];
        end

        if (r == MAX_HEIGHT - 1) begin : g_dn_wrap
            assign dn_l = r_left[0];
            assign dn_c = r_mid[0];
            assign dn_r = q[0];
        end else begin : g_dn
            logic dn_fold;
            assign dn_fold = (GHW'(r + 1) == r_gh);
            assign dn_l = dn_fold ? r_left[0] : r_left[r+1];
            assign dn_c = dn_fold ? r_mid[0]  : r_mid[r+1];
            assign dn_r = dn_fold ? q[0]      : q[r+1];
        end

        assign alive = r_mid[r];
        assign cnt   = 4'(up_l) + 4'(up_c) + 4'(up_r) + 4'(r_left[r]) + 4'(q[r]) +
                       4'(dn_l) + 4'(dn_c) + 4'(dn_r);

        // Rows past the height keep their value
        assign life_col[r] = (GHW'(r) < r_gh) ?
                             (alive ? ((cnt == LIFE_KEEP) || (cnt == LIFE_BIRTH))
                                    : (cnt == LIFE_BIRTH))
                             : alive;
    end

    // Write port selection
    always_comb begin
        cell_new        = q;
        cell_new[r_row] = r_val;
    end

    assign step_wr   = r_rd_step && (r_rd_tag >= KW'(2));
    assign step_calc = (r_rd_tag <= gw_k + 1'b1);
    assign cell_wr   = i_cmd.cell_upd && (r_func == FUNC_WRITE);
    assign wdata     = step_wr ? (step_calc ? life_col : q) : cell_new;
    assign waddr     = step_wr ? CW'(r_rd_tag - KW'(2)) : r_col;
    assign we_a      = (step_wr && r_bank)  || (cell_wr && !r_bank);
    assign we_b      = (step_wr && !r_bank) || (cell_wr && r_bank);

    // Column valid flags, bank select and generation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
            r_bank  <= 1'b0;
            r_gen   <= '0;
        end else begin
            if (we_a) begin
                r_vld_a[waddr] <= 1'b1;
            end
            if (we_b) begin
                r_vld_b[waddr] <= 1'b1;
            end
            if (i_cmd.step_fin) begin
                r_bank <= ~r_bank;
                r_gen  <= r_gen + 1'b1;
            end
        end
    end

    // Sampled cell for a read request
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rv <= 1'b0;
        end else if (i_cmd.cell_upd && (r_func == FUNC_READ)) begin
            r_rv <= q[r_row];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_out_data              <= '0;
            r_out_data[OUT_RV_BIT]  <= r_rv;
            r_out_data[OUT_GEN_LSB +: GEN_W] <= r_gen;
            r_out_data[OUT_OOR_BIT] <= r_oor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status to the controller
    assign o_sts.func       = r_func;
    assign o_sts.oor        = r_oor;
    assign o_sts.sweep_last = (r_k == K_LAST);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

endmodule

[rtl/core/tlgs_checker.sv]
// Port-level checker for the life grid block, bound to the top level.
// Depends on tlgs_pkg for the result field layout.
module tlgs_checker
    import tlgs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // One request at a time: ready drops after a request is taken
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while busy");

    // An out-of-range access never returns a live cell
    a_oor_rv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        !(o_m_axis_tdata[OUT_OOR_BIT] && o_m_axis_tdata[OUT_RV_BIT]))
        else $error("read value set on out-of-range result");

endmodule

bind toroidal_life_grid_step_top tlgs_checker u_tlgs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
